// File: src/sti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types, constants and command codes for the sorted table block.
// ----------------------------------------------------------------------------
package sti_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the request and result items
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic [OPCODE_W-1:0]       opcode_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [STATUS_W-1:0]       status_t;

  // Opcodes
  localparam opcode_t OP_INSERT  = 3'd0;
  localparam opcode_t OP_PREPEND = 3'd1;
  localparam opcode_t OP_APPEND  = 3'd2;
  localparam opcode_t OP_REMOVE  = 3'd3;
  localparam opcode_t OP_READ    = 3'd4;
  localparam opcode_t OP_CHECK   = 3'd5;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_BAD_INDEX = 2'd2;

  // Datapath actions, one per cycle
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_READ,
    ACT_SHIFT_UP,
    ACT_SHIFT_DOWN,
    ACT_PLACE,
    ACT_DEC,
    ACT_ERR_FULL,
    ACT_ERR_INDEX,
    ACT_CAPTURE,
    ACT_CHK_STEP,
    ACT_CHK_DONE,
    ACT_CHK_FAIL,
    ACT_EMIT,
    ACT_SCAN,
    ACT_CARRY
  } act_t;

  typedef struct packed {
    act_t act;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    idx_bad;
    logic    ptr_zero;
    logic    rm_last;
    logic    chk_end;
    logic    shift_go;
    logic    chk_lt;
  } dp_stat_t;

endpackage

// File: src/sti_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_item_if / sti_result_if
// Valid/ready channels for requests and results of the sorted table.
// ----------------------------------------------------------------------------
interface sti_item_if import sti_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  value_t  value;
  index_t  index;

  modport source (output valid, output opcode, output value, output index, input ready);
  modport sink (input valid, input opcode, input value, input index, output ready);
endinterface

interface sti_result_if import sti_pkg::*; ();
  logic                valid;
  logic                ready;
  value_t              read_value;
  logic [COUNT_W-1:0]  entry_count;
  logic                is_sorted;
  status_t             status;

  modport source (output valid, output read_value, output entry_count, output is_sorted,
                  output status, input ready);
  modport sink (input valid, input read_value, input entry_count, input is_sorted,
                input status, output ready);
endinterface

// File: src/sti_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_datapath
// Entry memory, count, work pointer, result and output registers.
// ----------------------------------------------------------------------------
module sti_datapath import sti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  opcode_t            opcode,
  input  value_t             value,
  input  index_t             index,
  output value_t             read_value,
  output logic [COUNT_W-1:0] entry_count,
  output logic               is_sorted,
  output status_t            status
);

  // Entry store: one write port, two registered read ports
  value_t mem [CAPACITY];
  value_t rd_a;
  value_t rd_b;

  opcode_t op;
  value_t  val;
  index_t  idx;
  cnt_t    ptr;
  cnt_t    count;
  logic    found;

  value_t  res_rv;
  logic    res_sorted;
  status_t res_status;

  cnt_t  ptr_inc;
  cnt_t  ptr_dec;
  cnt_t  idx_ext;
  addr_t addr_a;
  addr_t addr_b;

  assign ptr_inc = ptr + cnt_t'(1);
  assign ptr_dec = ptr - cnt_t'(1);
  assign idx_ext = cnt_t'(idx);

  // Read addresses: neighbor below for prepend/check, above for remove
  always_comb begin
    case (op)
      OP_REMOVE: addr_a = ptr_inc[ADDR_W-1:0];
      OP_READ:   addr_a = idx_ext[ADDR_W-1:0];
      default:   addr_a = ptr_dec[ADDR_W-1:0];
    endcase
    addr_b = ptr[ADDR_W-1:0];
  end

  // Status toward the controller
  always_comb begin
    stat.op       = op;
    stat.full     = (count == cnt_t'(CAPACITY));
    stat.idx_bad  = (idx_ext >= count);
    stat.ptr_zero = (ptr == '0);
    stat.rm_last  = (ptr_inc >= count);
    stat.chk_end  = (ptr >= count);
    // insert: slot found once an entry is not smaller, then carry the rest up
    stat.shift_go = found || !(rd_b < val);
    stat.chk_lt   = (rd_a < rd_b);
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (cmd.act == ACT_READ) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
    if (cmd.act == ACT_SHIFT_UP || cmd.act == ACT_SHIFT_DOWN) begin
      mem[ptr[ADDR_W-1:0]] <= rd_a;
    end else if (cmd.act == ACT_PLACE || cmd.act == ACT_CARRY) begin
      mem[ptr[ADDR_W-1:0]] <= val;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.act == ACT_PLACE) begin
      count <= count + cnt_t'(1);
    end else if (cmd.act == ACT_DEC) begin
      count <= count - cnt_t'(1);
    end
  end

  // Request capture, pointer and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      ACT_LOAD: begin
        op         <= opcode;
        val        <= value;
        idx        <= index;
        found      <= 1'b0;
        res_rv     <= '0;
        res_sorted <= 1'b0;
        res_status <= ST_OK;
        case (opcode)
          OP_INSERT:          ptr <= '0;
          OP_REMOVE, OP_READ: ptr <= cnt_t'(index);
          OP_CHECK:           ptr <= cnt_t'(1);
          default:            ptr <= count;
        endcase
      end
      ACT_SHIFT_UP:   ptr <= ptr_dec;
      ACT_SHIFT_DOWN: ptr <= ptr_inc;
      ACT_CHK_STEP:   ptr <= ptr_inc;
      ACT_SCAN:       ptr <= ptr_inc;
      // store the carried value and pick up the displaced entry
      ACT_CARRY: begin
        ptr   <= ptr_inc;
        val   <= rd_b;
        found <= 1'b1;
      end
      ACT_ERR_FULL:   res_status <= ST_FULL;
      ACT_ERR_INDEX:  res_status <= ST_BAD_INDEX;
      ACT_CAPTURE:    res_rv <= rd_a;
      ACT_CHK_DONE:   res_sorted <= 1'b1;
      ACT_CHK_FAIL:   res_sorted <= 1'b0;
      ACT_EMIT: begin
        read_value  <= res_rv;
        entry_count <= COUNT_W'(count);
        is_sorted   <= res_sorted;
        status      <= res_status;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/sti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_ctrl
// Sequencer for one request at a time, plus the result valid flag.
// ----------------------------------------------------------------------------
module sti_ctrl import sti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  output logic     res_valid,
  input  logic     res_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_USE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !res_valid || res_ready;

  // Next action and state
  always_comb begin
    cmd.act    = ACT_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.act    = ACT_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        case (stat.op)
          // forward walk; the last carried value lands at the end
          OP_INSERT: begin
            if (stat.full) begin
              cmd.act = ACT_ERR_FULL;
            end else if (stat.chk_end) begin
              cmd.act = ACT_PLACE;
            end else begin
              cmd.act    = ACT_READ;
              state_next = S_USE;
            end
          end
          OP_PREPEND: begin
            if (stat.full) begin
              cmd.act = ACT_ERR_FULL;
            end else if (stat.ptr_zero) begin
              cmd.act = ACT_PLACE;
            end else begin
              cmd.act    = ACT_READ;
              state_next = S_USE;
            end
          end
          OP_APPEND: cmd.act = stat.full ? ACT_ERR_FULL : ACT_PLACE;
          OP_REMOVE: begin
            if (stat.idx_bad) begin
              cmd.act = ACT_ERR_INDEX;
            end else if (stat.rm_last) begin
              cmd.act = ACT_DEC;
            end else begin
              cmd.act    = ACT_READ;
              state_next = S_USE;
            end
          end
          OP_READ: begin
            if (stat.idx_bad) begin
              cmd.act = ACT_ERR_INDEX;
            end else begin
              cmd.act    = ACT_READ;
              state_next = S_USE;
            end
          end
          OP_CHECK: begin
            if (stat.chk_end) begin
              cmd.act = ACT_CHK_DONE;
            end else begin
              cmd.act    = ACT_READ;
              state_next = S_USE;
            end
          end
          default: cmd.act = ACT_NONE;
        endcase
      end
      S_USE: begin
        state_next = S_FINISH;
        case (stat.op)
          OP_INSERT: begin
            cmd.act    = stat.shift_go ? ACT_CARRY : ACT_SCAN;
            state_next = S_DISPATCH;
          end
          OP_PREPEND: begin
            cmd.act    = ACT_SHIFT_UP;
            state_next = S_DISPATCH;
          end
          OP_REMOVE: begin
            cmd.act    = ACT_SHIFT_DOWN;
            state_next = S_DISPATCH;
          end
          OP_READ: cmd.act = ACT_CAPTURE;
          OP_CHECK: begin
            if (stat.chk_lt) begin
              cmd.act    = ACT_CHK_STEP;
              state_next = S_DISPATCH;
            end else begin
              cmd.act = ACT_CHK_FAIL;
            end
          end
          default: cmd.act = ACT_NONE;
        endcase
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.act    = ACT_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.act == ACT_EMIT) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/sorted_table_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_remove
// Bounded table of signed 32-bit entries with sorted insert, prepend, append,
// remove, read and order check; one result per request.
// ----------------------------------------------------------------------------
// Requests are handled one at a time through a single entry memory with one
// write and two registered read ports. Append, errors and unused opcodes go
// straight from dispatch to the result; read visits one entry; sorted insert
// and prepend visit every entry present before the request (insert walks
// every entry from the front, passing over smaller ones and carrying the rest
// up one place; prepend moves every entry up); remove visits the entries
// above the index; check visits neighbor pairs until one is out of order.
// Each visited entry takes a memory read followed by a use step. A new
// request is taken once the previous result sits in the output register,
// which holds it until the sink takes it.
module sorted_table_insert_remove import sti_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  sti_item_if.sink            item,
  sti_result_if.source        result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sti_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sti_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (item.opcode),
    .value       (item.value),
    .index       (item.index),
    .read_value  (result.read_value),
    .entry_count (result.entry_count),
    .is_sorted   (result.is_sorted),
    .status      (result.status)
  );

endmodule

// File: test/sorted_table_insert_remove_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_test
// Self-checking bench for the sorted table. A short table of directed requests
// covers the empty table, the value extremes, every opcode, equal values and
// bad indexes. Random epochs then grow the table to full, shrink it and mix in
// noise. A local table model predicts each result. Requests come in bursts
// with gaps, and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_test;
  import sti_pkg::*;

  // Opcodes the block ignores
  localparam opcode_t OP_SPARE6 = 3'd6;
  localparam opcode_t OP_SPARE7 = 3'd7;

  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_REQUESTS = 1500;
  localparam int MAX_REPORTS     = 10;
  localparam int SETTLE_CYCLES   = 20;

  typedef struct packed {
    value_t             read_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_sorted;
    status_t            status;
  } result_t;

  // Directed row: fixed = 1 when the expected result is typed in
  typedef struct packed {
    opcode_t op;
    value_t  val;
    index_t  idx;
    logic    fixed;
    result_t want;
  } dir_row_t;

  typedef struct packed {
    logic    fixed;
    result_t want;
  } pin_t;

  logic clk = 1'b0;
  logic rst;

  sti_item_if   req_ch ();
  sti_result_if res_ch ();

  sorted_table_insert_remove dut (
    .clk    (clk),
    .rst    (rst),
    .item   (req_ch),
    .result (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Table model and result bookkeeping
  value_t   table_mem [CAPACITY];
  int       table_count;
  result_t  pending_results [$];
  pin_t     fixed_results [$];
  dir_row_t dir_rows [$];
  int       fail_count;
  int       burst_left;
  int       stall_mode;
  int       stall_left;

  // Apply one request to the table model and return its result
  function automatic result_t apply_to_table(opcode_t op, value_t val, index_t idx);
    result_t r;
    int      pos;
    int      i;
    r = '0;
    case (op)
      OP_INSERT, OP_PREPEND, OP_APPEND: begin
        if (table_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_INSERT) begin
            // first entry not smaller than the new value
            pos = 0;
            while (pos < table_count && table_mem[pos] < val) pos++;
          end else if (op == OP_PREPEND) begin
            pos = 0;
          end else begin
            pos = table_count;
          end
          for (i = table_count; i > pos; i--) table_mem[i] = table_mem[i-1];
          table_mem[pos] = val;
          table_count++;
        end
      end
      OP_REMOVE: begin
        if (int'(idx) >= table_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = int'(idx); i + 1 < table_count; i++) table_mem[i] = table_mem[i+1];
          table_count--;
        end
      end
      OP_READ: begin
        if (int'(idx) >= table_count) r.status = ST_BAD_INDEX;
        else r.read_value = table_mem[idx];
      end
      OP_CHECK: begin
        // strictly increasing; equal neighbors fail
        r.is_sorted = 1'b1;
        for (i = 1; i < table_count; i++) begin
          if (!(table_mem[i-1] < table_mem[i])) begin
            r.is_sorted = 1'b0;
            break;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(table_count);
    return r;
  endfunction

  function automatic dir_row_t typed_row(opcode_t op, value_t val, index_t idx,
                                         value_t rv, int cnt, logic srt, status_t st);
    dir_row_t row;
    row.op                = op;
    row.val               = val;
    row.idx               = idx;
    row.fixed             = 1'b1;
    row.want.read_value   = rv;
    row.want.entry_count  = COUNT_W'(cnt);
    row.want.is_sorted    = srt;
    row.want.status       = st;
    return row;
  endfunction

  function automatic dir_row_t open_row(opcode_t op, value_t val, index_t idx);
    dir_row_t row;
    row       = '0;
    row.op    = op;
    row.val   = val;
    row.idx   = idx;
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Mix of full-range, small (many equal values) and extreme values
  function automatic value_t pick_value();
    case ($urandom_range(0, 3))
      1: return value_t'(int'($urandom_range(0, 31)) - 16);
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  // Mostly in-range indexes so removes and reads do real work
  function automatic index_t pick_index();
    if (table_count > 0 && $urandom_range(0, 9) < 8)
      return index_t'($urandom_range(0, table_count - 1));
    return index_t'($urandom_range(0, 63));
  endfunction

  // Opcode mix per epoch: 0 sorted growth, 1 any growth, 2 shrink, 3 noise
  function automatic opcode_t pick_opcode(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 75) return OP_INSERT;
        if (r < 85) return OP_READ;
        if (r < 93) return OP_CHECK;
        return OP_REMOVE;
      end
      1: begin
        if (r < 30) return OP_INSERT;
        if (r < 55) return OP_PREPEND;
        if (r < 80) return OP_APPEND;
        if (r < 88) return OP_READ;
        if (r < 94) return OP_CHECK;
        return OP_REMOVE;
      end
      2: begin
        if (r < 65) return OP_REMOVE;
        if (r < 80) return OP_READ;
        if (r < 88) return OP_CHECK;
        if (r < 96) return OP_INSERT;
        return OP_APPEND;
      end
      default: return opcode_t'($urandom_range(0, 7));
    endcase
  endfunction

  // Drive one request; bursts of random length separated by random gaps
  task automatic send_request(opcode_t op, value_t val, index_t idx);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.value  <= val;
    req_ch.index  <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Hold off new requests until every expected result has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result side ready: always, coin flip, or mostly stalled
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_mode   = 0;
      stall_left   = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= $urandom_range(0, 1);
        default: res_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin : monitor
    result_t predicted;
    result_t got;
    result_t want;
    pin_t    pin;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        predicted = apply_to_table(req_ch.opcode, req_ch.value, req_ch.index);
        pin = '0;
        if (fixed_results.size() != 0) pin = fixed_results.pop_front();
        pending_results.insert(pending_results.size(), pin.fixed ? pin.want : predicted);
      end
      if (res_ch.valid && res_ch.ready) begin
        got.read_value  = res_ch.read_value;
        got.entry_count = res_ch.entry_count;
        got.is_sorted   = res_ch.is_sorted;
        got.status      = res_ch.status;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result with no request pending: rv=%0d cnt=%0d sorted=%0b st=%0d",
                     $realtime, got.read_value, got.entry_count, got.is_sorted, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: expected rv=%0d cnt=%0d sorted=%0b st=%0d, got rv=%0d cnt=%0d sorted=%0b st=%0d",
                       $realtime, want.read_value, want.entry_count, want.is_sorted,
                       want.status, got.read_value, got.entry_count, got.is_sorted,
                       got.status);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int      mode;
    int      sent;
    int      epoch_len;
    opcode_t op;
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.opcode = OP_INSERT;
    req_ch.value  = '0;
    req_ch.index  = '0;
    table_count   = 0;
    fail_count    = 0;
    burst_left    = 0;
    foreach (table_mem[i]) table_mem[i] = '0;

    // empty table, extremes, equal values, bad indexes, unused opcodes
    add_row(typed_row(OP_CHECK,   '0,      6'd0,  '0,      0, 1'b1, ST_OK));
    add_row(typed_row(OP_READ,    '0,      6'd0,  '0,      0, 1'b0, ST_BAD_INDEX));
    add_row(typed_row(OP_REMOVE,  '0,      6'd63, '0,      0, 1'b0, ST_BAD_INDEX));
    add_row(typed_row(OP_INSERT,  '0,      6'd0,  '0,      1, 1'b0, ST_OK));
    add_row(typed_row(OP_INSERT,  VAL_MAX, 6'd0,  '0,      2, 1'b0, ST_OK));
    add_row(typed_row(OP_INSERT,  VAL_MIN, 6'd63, '0,      3, 1'b0, ST_OK));
    add_row(typed_row(OP_READ,    '0,      6'd0,  VAL_MIN, 3, 1'b0, ST_OK));
    add_row(typed_row(OP_READ,    '0,      6'd2,  VAL_MAX, 3, 1'b0, ST_OK));
    add_row(typed_row(OP_CHECK,   '0,      6'd0,  '0,      3, 1'b1, ST_OK));
    add_row(typed_row(OP_INSERT,  '0,      6'd0,  '0,      4, 1'b0, ST_OK));
    add_row(typed_row(OP_CHECK,   '0,      6'd0,  '0,      4, 1'b0, ST_OK));
    add_row(typed_row(OP_READ,    '0,      6'd63, '0,      4, 1'b0, ST_BAD_INDEX));
    add_row(typed_row(OP_REMOVE,  '0,      6'd1,  '0,      3, 1'b0, ST_OK));
    add_row(typed_row(OP_PREPEND, '1,      6'd0,  '0,      4, 1'b0, ST_OK));
    add_row(typed_row(OP_CHECK,   '0,      6'd0,  '0,      4, 1'b0, ST_OK));
    add_row(typed_row(OP_APPEND,  -32'sd5, 6'd0,  '0,      5, 1'b0, ST_OK));
    add_row(typed_row(OP_READ,    '0,      6'd4,  -32'sd5, 5, 1'b0, ST_OK));
    add_row(typed_row(OP_SPARE6,  '1,      6'd63, '0,      5, 1'b0, ST_OK));
    add_row(typed_row(OP_SPARE7,  '1,      6'd0,  '0,      5, 1'b0, ST_OK));
    add_row(typed_row(OP_REMOVE,  '0,      6'd4,  '0,      4, 1'b0, ST_OK));
    add_row(typed_row(OP_REMOVE,  '0,      6'd0,  '0,      3, 1'b0, ST_OK));
    add_row(typed_row(OP_READ,    '0,      6'd3,  '0,      3, 1'b0, ST_BAD_INDEX));
    add_row(open_row(OP_INSERT,   32'sh5555_5555, 6'd21));
    add_row(open_row(OP_APPEND,   32'shaaaa_aaaa, 6'd42));
    add_row(open_row(OP_CHECK,    '0,             6'd0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      fixed_results.insert(fixed_results.size(), {dir_rows[i].fixed, dir_rows[i].want});
      send_request(dir_rows[i].op, dir_rows[i].val, dir_rows[i].idx);
    end
    wait_drained();

    // Random epochs; growth runs fill the table so adds hit the full case
    mode = 0;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      epoch_len = $urandom_range(60, 160);
      repeat (epoch_len) begin
        op = pick_opcode(mode);
        fixed_results.insert(fixed_results.size(), '0);
        if (mode == 3)
          send_request(op, value_t'($urandom), index_t'($urandom_range(0, 63)));
        else
          send_request(op, pick_value(), pick_index());
        sent++;
      end
      mode = (mode + 1) % 4;
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
